// ----- rtl/core/ism_pkg.sv -----
`timescale 1ns / 1ps

package ism_pkg;

    localparam int COUNT_BITS = 32;
    localparam int ELEM_BITS  = 32;
    localparam int SUM_BITS   = 64;
    localparam int MEAN_BITS  = 32;

    localparam logic [MEAN_BITS-1:0] MEAN_MIN = {1'b1, {(MEAN_BITS-1){1'b0}}};
    localparam logic [MEAN_BITS-1:0] MEAN_MAX = {1'b0, {(MEAN_BITS-1){1'b1}}};

    typedef struct packed {
        logic accept;
        logic abs_en;
        logic div_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

// ----- rtl/core/ism_ctrl.sv -----
`timescale 1ns / 1ps

module ism_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             segment_end,
    output logic             in_stall,
    input  ism_pkg::status_t status,
    output ism_pkg::cmd_t    cmd
);

    localparam int STEP_BITS = $clog2(ism_pkg::SUM_BITS);
    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(ism_pkg::SUM_BITS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ABS,
        ST_DIV,
        ST_WRITE
    } state_t;

    state_t               state_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic                 accept;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        cmd          = '0;
        cmd.accept   = accept;
        cmd.abs_en   = (state_reg == ST_ABS);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.load_out = (state_reg == ST_WRITE) && status.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && segment_end)
                    begin
                        state_reg <= ST_ABS;
                    end
                end
                ST_ABS:
                begin
                    step_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == LAST_STEP)
                    begin
                        state_reg <= ST_WRITE;
                    end
                end
                ST_WRITE:
                begin
                    if (status.out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/ism_dp.sv -----
`timescale 1ns / 1ps

module ism_dp
#(
    parameter int COUNT_BITS = ism_pkg::COUNT_BITS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic signed [ism_pkg::ELEM_BITS-1:0] element,
    input  logic                                segment_end,
    input  ism_pkg::cmd_t                       cmd,
    output ism_pkg::status_t                    status,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [ism_pkg::MEAN_BITS-1:0] mean
);

    localparam int SB = ism_pkg::SUM_BITS;
    localparam int EB = ism_pkg::ELEM_BITS;
    localparam int MB = ism_pkg::MEAN_BITS;

    logic [SB-1:0]         sum_reg;
    logic [SB-1:0]         sum_next;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic [COUNT_BITS-1:0] cnt_next;

    logic [COUNT_BITS-1:0] rem_reg;
    logic [SB-1:0]         quo_reg;
    logic [COUNT_BITS-1:0] div_reg;
    logic                  neg_reg;

    logic [MB-1:0]         mean_reg;
    logic [MB-1:0]         mean_next;
    logic                  out_valid_reg;

    logic [COUNT_BITS:0]   shifted;
    logic [COUNT_BITS:0]   trial;
    logic                  fits;
    logic                  too_big;

    // accumulate with wrapping sum and saturating count
    always_comb
    begin
        sum_next = sum_reg + {{(SB-EB){element[EB-1]}}, element};
        cnt_next = (&cnt_reg) ? cnt_reg : cnt_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.accept)
        begin
            if (segment_end)
            begin
                sum_reg <= '0;
                cnt_reg <= '0;
            end
            else
            begin
                sum_reg <= sum_next;
                cnt_reg <= cnt_next;
            end
        end
    end

    // restoring divider, one quotient bit per cycle
    always_comb
    begin
        shifted = {rem_reg, quo_reg[SB-1]};
        trial   = shifted - {1'b0, div_reg};
        fits    = (shifted >= {1'b0, div_reg});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && segment_end)
        begin
            quo_reg <= sum_next;
            neg_reg <= sum_next[SB-1];
            div_reg <= cnt_next;
        end
        else if (cmd.abs_en)
        begin
            quo_reg <= neg_reg ? (SB'(0) - quo_reg) : quo_reg;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= fits ? trial[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
            quo_reg <= {quo_reg[SB-2:0], fits};
        end
    end

    // clamp and restore sign
    always_comb
    begin
        if (neg_reg)
        begin
            too_big   = (|quo_reg[SB-1:MB]) || (quo_reg[MB-1] && (|quo_reg[MB-2:0]));
            mean_next = too_big ? ism_pkg::MEAN_MIN : (MB'(0) - quo_reg[MB-1:0]);
        end
        else
        begin
            too_big   = |quo_reg[SB-1:MB-1];
            mean_next = too_big ? ism_pkg::MEAN_MAX : quo_reg[MB-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            mean_reg <= mean_next;
        end
    end

    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign mean            = mean_reg;

endmodule

// ----- rtl/core/int_segment_mean.sv -----
// elements without the end mark are taken one per cycle while in_stall is low
// the last element of a segment starts a 64-step restoring divide, one bit per cycle
// the mean is then clamped and loaded into the output register, input stalled meanwhile
// the output register holds the mean so the next segment can start while it waits
// asynchronous active-low reset clears sum, count, controller and output valid
`timescale 1ns / 1ps

module int_segment_mean
#(
    parameter int COUNT_BITS = ism_pkg::COUNT_BITS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [ism_pkg::ELEM_BITS-1:0] element,
    input  logic                                segment_end,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [ism_pkg::MEAN_BITS-1:0] mean
);

    ism_pkg::cmd_t    cmd;
    ism_pkg::status_t status;

    ism_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .segment_end (segment_end),
        .in_stall    (in_stall),
        .status      (status),
        .cmd         (cmd)
    );

    ism_dp
    #(
        .COUNT_BITS (COUNT_BITS)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .element     (element),
        .segment_end (segment_end),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .mean        (mean)
    );

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam int RANDOM_ITEMS = 1650;
    localparam int QUIET_AFTER  = 1400;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DIR_ROWS     = 22;

    typedef struct packed {
        logic signed [ism_pkg::ELEM_BITS-1:0] elem;
        logic                                 last;
        logic                                 typed;
        logic signed [ism_pkg::MEAN_BITS-1:0] mean_val;
    } dir_row_t;

    logic                                 clk         = 1'b0;
    logic                                 rst_n       = 1'b0;
    logic                                 in_valid    = 1'b0;
    logic                                 in_stall;
    logic signed [ism_pkg::ELEM_BITS-1:0] element     = '0;
    logic                                 segment_end = 1'b0;
    logic                                 out_valid;
    logic                                 out_stall   = 1'b0;
    logic signed [ism_pkg::MEAN_BITS-1:0] mean;

    logic signed [ism_pkg::SUM_BITS-1:0]  sum_acc     = '0;
    logic [ism_pkg::COUNT_BITS-1:0]       elem_count  = '0;
    logic signed [ism_pkg::MEAN_BITS-1:0] expected_means [$];

    int error_count  = 0;
    int cycle_count  = 0;
    int stall_left   = 0;
    bit tail_quiet   = 1'b0;

    localparam logic signed [ism_pkg::ELEM_BITS-1:0] EL_MAX = ism_pkg::MEAN_MAX;
    localparam logic signed [ism_pkg::ELEM_BITS-1:0] EL_MIN = ism_pkg::MEAN_MIN;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{32'sd0,         1'b1, 1'b1, 32'sd0},
        '{EL_MAX,         1'b1, 1'b1, ism_pkg::MEAN_MAX},
        '{EL_MIN,         1'b1, 1'b1, ism_pkg::MEAN_MIN},
        '{EL_MAX,         1'b0, 1'b0, 32'sd0},
        '{EL_MAX,         1'b1, 1'b1, ism_pkg::MEAN_MAX},
        '{EL_MIN,         1'b0, 1'b0, 32'sd0},
        '{EL_MIN,         1'b1, 1'b1, ism_pkg::MEAN_MIN},
        '{-32'sd1,        1'b1, 1'b1, -32'sd1},
        '{-32'sd3,        1'b0, 1'b0, 32'sd0},
        '{32'sd0,         1'b1, 1'b1, -32'sd1},
        '{32'sd3,         1'b0, 1'b0, 32'sd0},
        '{32'sd0,         1'b1, 1'b1, 32'sd1},
        '{EL_MAX,         1'b0, 1'b0, 32'sd0},
        '{EL_MIN,         1'b1, 1'b1, 32'sd0},
        '{32'sd7,         1'b0, 1'b0, 32'sd0},
        '{-32'sd8,        1'b0, 1'b0, 32'sd0},
        '{32'sd5,         1'b1, 1'b0, 32'sd0},
        '{32'sh5555_5555, 1'b0, 1'b0, 32'sd0},
        '{32'shAAAA_AAAA, 1'b0, 1'b0, 32'sd0},
        '{32'sd1,         1'b0, 1'b0, 32'sd0},
        '{-32'sd2,        1'b1, 1'b0, 32'sd0},
        '{32'sh0000_FFFF, 1'b1, 1'b1, 32'sd65535}
    };

    int_segment_mean uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .element     (element),
        .segment_end (segment_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .mean        (mean)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // drive one request, then fold the accepted element into the running sum and count
    task automatic send_request(input logic signed [ism_pkg::ELEM_BITS-1:0] e,
                                input logic last, input logic typed,
                                input logic signed [ism_pkg::MEAN_BITS-1:0] typed_mean);
        logic signed [ism_pkg::SUM_BITS:0]    quot;
        logic signed [ism_pkg::MEAN_BITS-1:0] predicted;
        if (!tail_quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        element     <= e;
        segment_end <= last;
        do
            @(posedge clk);
        while (in_stall);
        sum_acc = sum_acc
                + {{(ism_pkg::SUM_BITS-ism_pkg::ELEM_BITS){e[ism_pkg::ELEM_BITS-1]}}, e};
        if (elem_count != {ism_pkg::COUNT_BITS{1'b1}})
            elem_count = elem_count + 1'b1;
        if (last)
        begin
            quot = $signed({sum_acc[ism_pkg::SUM_BITS-1], sum_acc})
                 / $signed({{(ism_pkg::SUM_BITS+1-ism_pkg::COUNT_BITS){1'b0}}, elem_count});
            if (quot > 65'sd2147483647)
                predicted = ism_pkg::MEAN_MAX;
            else if (quot < -65'sd2147483648)
                predicted = ism_pkg::MEAN_MIN;
            else
                predicted = quot[ism_pkg::MEAN_BITS-1:0];
            expected_means.push_back(typed ? typed_mean : predicted);
            sum_acc    = '0;
            elem_count = '0;
        end
    endtask

    initial
    begin
        int sent;
        int seg_len;
        int k;
        logic signed [ism_pkg::ELEM_BITS-1:0] value;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int r = 0; r < DIR_ROWS; r++)
            send_request(dir_rows[r].elem, dir_rows[r].last, dir_rows[r].typed,
                         dir_rows[r].mean_val);
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
                seg_len = $urandom_range(9, 64);
            else
                seg_len = $urandom_range(1, 8);
            for (k = 0; k < seg_len; k++)
            begin
                case ($urandom_range(0, 7))
                    0: value = EL_MAX;
                    1: value = EL_MIN;
                    2: value = $signed($urandom_range(0, 200)) - 32'sd100;
                    default: value = $urandom;
                endcase
                tail_quiet = (sent >= QUIET_AFTER);
                send_request(value, k == seg_len - 1, 1'b0, '0);
                sent++;
            end
        end
        in_valid <= 1'b0;
        while (expected_means.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    always @(posedge clk)
    begin
        logic signed [ism_pkg::MEAN_BITS-1:0] want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_means.size() == 0)
                    report_error($sformatf("mean %0d with no request pending", mean));
                else
                begin
                    want = expected_means.pop_front();
                    if (mean !== want)
                        report_error($sformatf("mean %0d, expected %0d", mean, want));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!tail_quiet && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 9);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule
